FILE: rtl/pfsa_pkg.sv
package pfsa_pkg;

    // pool geometry
    localparam int MAX_PAGES = 4096;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int CNT_W     = PAGE_W + 1;

    // field widths
    localparam int ACT_W     = 2;
    localparam int FIRST_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int ADDR_W    = 64;
    localparam int BASE_W    = 48;
    localparam int PSIZE_W   = 31;
    localparam int CTRL_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PAGES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USABLE_PAGES  = 2'd3;

    // actions
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FREE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RESERVED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd5;

    // page states
    localparam logic [1:0] PG_FREE = 2'd0;
    localparam logic [1:0] PG_USED = 2'd1;
    localparam logic [1:0] PG_RSVD = 2'd2;

    // per-page entry: state and position in the free stack
    typedef struct packed {
        logic [1:0]        st;
        logic [PAGE_W-1:0] pos;
    } page_info_t;

endpackage

FILE: rtl/pfsa_in_if.sv
interface pfsa_in_if;
    logic                        valid;
    logic                        ready;
    logic [pfsa_pkg::ACT_W-1:0]   action;
    logic [pfsa_pkg::FIRST_W-1:0] first_page;
    logic [pfsa_pkg::CNT_W-1:0]   page_count;

    modport source (output valid, action, first_page, page_count, input ready);
    modport sink   (input valid, action, first_page, page_count, output ready);
endinterface

FILE: rtl/pfsa_out_if.sv
interface pfsa_out_if;
    logic                         valid;
    logic                         ready;
    logic [pfsa_pkg::STATUS_W-1:0] status;
    logic [pfsa_pkg::ADDR_W-1:0]   address;
    logic [pfsa_pkg::CNT_W-1:0]    pages_done;
    logic [pfsa_pkg::CNT_W-1:0]    free_pages;

    modport source (output valid, status, address, pages_done, free_pages, input ready);
    modport sink   (input valid, status, address, pages_done, free_pages, output ready);
endinterface

FILE: rtl/pfsa_cfg_if.sv
interface pfsa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfsa_pkg::CFG_IDX_W-1:0]  idx;
    logic [pfsa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

FILE: rtl/pfsa_ram.sv
module pfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/page_frame_stack_allocator.sv
// allocate: check, multiply and add states, then done loads the result register; reserve
// range: page read, evaluate, move and mark per page; free range: page read and evaluate
// per page (page memory read, then stack memory read and write-back on the single ports)
// one item at a time; the next transaction is accepted once the result moves to the output
// reset and every usable_pages write start a pass that initializes all entries of both page
// memories; no input transaction is accepted during it, config writes still are
module page_frame_stack_allocator (
    input  logic              clk,
    input  logic              rst_n,
    pfsa_in_if.sink           req,
    pfsa_out_if.source        rsp,
    pfsa_cfg_if.sink          cfg
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_CHECK     = 4'd2;
    localparam logic [3:0] S_ALLOC_MUL = 4'd3;
    localparam logic [3:0] S_ALLOC_ADD = 4'd4;
    localparam logic [3:0] S_PG_RD     = 4'd5;
    localparam logic [3:0] S_PG_EVAL   = 4'd6;
    localparam logic [3:0] S_RSV_MOVE  = 4'd7;
    localparam logic [3:0] S_RSV_MARK  = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    localparam int PW  = pfsa_pkg::PAGE_W;
    localparam int CW  = pfsa_pkg::CNT_W;
    localparam int P1W = pfsa_pkg::CTRL_W + pfsa_pkg::PSIZE_W;
    localparam int P2W = PW + pfsa_pkg::PSIZE_W;
    localparam int RW  = pfsa_pkg::FIRST_W + 1;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [CW-1:0] fc_reg, fc_next;
    logic [CW-1:0] pool_reg, pool_next;
    logic          out_valid_reg, out_valid_next;

    // configuration
    logic [pfsa_pkg::BASE_W-1:0]  base_reg, base_next;
    logic [pfsa_pkg::PSIZE_W-1:0] psize_reg, psize_next;
    logic [pfsa_pkg::CTRL_W-1:0]  ctrl_reg, ctrl_next;

    // operation payload
    logic [pfsa_pkg::ACT_W-1:0]    act_reg, act_next;
    logic [pfsa_pkg::FIRST_W-1:0]  first_reg, first_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [PW-1:0]                 j_reg, j_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 done_reg, done_next;
    logic [pfsa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pfsa_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [P1W-1:0]                p1_reg, p1_next;
    logic [P2W-1:0]                p2_reg, p2_next;

    // output register
    logic [pfsa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [pfsa_pkg::ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [CW-1:0]                 out_done_reg, out_done_next;
    logic [CW-1:0]                 out_free_reg, out_free_next;

    // memory ports
    logic                   a_we;
    logic [PW-1:0]          a_waddr, a_wdata, a_raddr, a_rdata;
    logic                   b_we;
    logic [PW-1:0]          b_waddr, b_raddr;
    pfsa_pkg::page_info_t   b_wdata, b_rdata;

    // helpers
    logic [CW-1:0]                fc_dec;
    logic [pfsa_pkg::FIRST_W-1:0] start_full;
    logic                         out_of_range;
    logic [CW-1:0]                pool_wr;

    // free stack: slot -> page index
    pfsa_ram #(
        .WIDTH (PW),
        .DEPTH (pfsa_pkg::MAX_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // page info: page index -> state and stack slot
    pfsa_ram #(
        .WIDTH ($bits(pfsa_pkg::page_info_t)),
        .DEPTH (pfsa_pkg::MAX_PAGES)
    ) u_info_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // range check and address products
    assign fc_dec       = fc_reg - CW'(1);
    assign start_full   = first_reg - ctrl_reg;
    assign out_of_range = (first_reg < ctrl_reg) ||
                          ((RW'(first_reg) + RW'(count_reg)) > (RW'(ctrl_reg) + RW'(pool_reg)));
    assign pool_wr      = (cfg.data[CW-1:0] > CW'(pfsa_pkg::MAX_PAGES)) ?
                          CW'(pfsa_pkg::MAX_PAGES) : cfg.data[CW-1:0];
    assign p1_next      = P1W'(ctrl_reg) * P1W'(psize_reg);

    // handshake outputs
    assign req.ready      = (state_reg == S_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.address    = out_addr_reg;
    assign rsp.pages_done = out_done_reg;
    assign rsp.free_pages = out_free_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        fc_next         = fc_reg;
        pool_next       = pool_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        base_next       = base_reg;
        psize_next      = psize_reg;
        ctrl_next       = ctrl_reg;
        act_next        = act_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        pos_next        = pos_reg;
        done_next       = done_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        p2_next         = p2_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_done_next   = out_done_reg;
        out_free_next   = out_free_reg;

        a_we      = 1'b0;
        a_waddr   = '0;
        a_wdata   = '0;
        a_raddr   = fc_dec[PW-1:0];
        b_we      = 1'b0;
        b_waddr   = j_reg;
        b_wdata   = '0;
        b_raddr   = j_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                a_we        = 1'b1;
                a_waddr     = clr_reg;
                a_wdata     = clr_reg;
                b_we        = 1'b1;
                b_waddr     = clr_reg;
                b_wdata.st  = pfsa_pkg::PG_FREE;
                b_wdata.pos = clr_reg;
                clr_next    = clr_reg + PW'(1);
                if (clr_reg == PW'(pfsa_pkg::MAX_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next   = req.action;
                    first_next = req.first_page;
                    count_next = req.page_count;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                addr_next = '0;
                done_next = '0;
                case (act_reg) inside
                    pfsa_pkg::ACT_ALLOC:
                    begin
                        if (fc_reg == '0)
                        begin
                            status_next = pfsa_pkg::ST_NONE_FREE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = pfsa_pkg::ST_OK;
                            state_next  = S_ALLOC_MUL;
                        end
                    end
                    pfsa_pkg::ACT_RESERVE, pfsa_pkg::ACT_FREE:
                    begin
                        if (out_of_range)
                        begin
                            status_next = pfsa_pkg::ST_OUT_OF_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            status_next = pfsa_pkg::ST_OK;
                            j_next      = start_full[PW-1:0];
                            state_next  = S_PG_RD;
                        end
                    end
                    default:
                    begin
                        status_next = pfsa_pkg::ST_OUT_OF_RANGE;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_ALLOC_MUL:
            begin
                // top of stack popped, page marked in use
                b_we        = 1'b1;
                b_waddr     = a_rdata;
                b_wdata.st  = pfsa_pkg::PG_USED;
                b_wdata.pos = '0;
                fc_next     = fc_dec;
                p2_next     = P2W'(a_rdata) * P2W'(psize_reg);
                state_next  = S_ALLOC_ADD;
            end
            S_ALLOC_ADD:
            begin
                addr_next  = pfsa_pkg::ADDR_W'(base_reg) + pfsa_pkg::ADDR_W'(p1_reg)
                           + pfsa_pkg::ADDR_W'(p2_reg);
                done_next  = CW'(1);
                state_next = S_DONE;
            end
            S_PG_RD:
            begin
                if (done_reg == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PG_EVAL;
                end
            end
            S_PG_EVAL:
            begin
                if (act_reg == pfsa_pkg::ACT_RESERVE)
                begin
                    if (b_rdata.st != pfsa_pkg::PG_FREE)
                    begin
                        status_next = pfsa_pkg::ST_NOT_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // top entry is being read for the swap
                        pos_next   = b_rdata.pos;
                        state_next = S_RSV_MOVE;
                    end
                end
                else if (b_rdata.st == pfsa_pkg::PG_FREE)
                begin
                    status_next = pfsa_pkg::ST_ALREADY_FREE;
                    state_next  = S_DONE;
                end
                else if (b_rdata.st != pfsa_pkg::PG_USED)
                begin
                    status_next = pfsa_pkg::ST_RESERVED;
                    state_next  = S_DONE;
                end
                else
                begin
                    // push page on the stack
                    a_we        = 1'b1;
                    a_waddr     = fc_reg[PW-1:0];
                    a_wdata     = j_reg;
                    b_we        = 1'b1;
                    b_waddr     = j_reg;
                    b_wdata.st  = pfsa_pkg::PG_FREE;
                    b_wdata.pos = fc_reg[PW-1:0];
                    fc_next     = fc_reg + CW'(1);
                    done_next   = done_reg + CW'(1);
                    j_next      = j_reg + PW'(1);
                    state_next  = S_PG_RD;
                end
            end
            S_RSV_MOVE:
            begin
                // top entry moves into the removed page's slot
                a_we        = 1'b1;
                a_waddr     = pos_reg;
                a_wdata     = a_rdata;
                b_we        = 1'b1;
                b_waddr     = a_rdata;
                b_wdata.st  = pfsa_pkg::PG_FREE;
                b_wdata.pos = pos_reg;
                state_next  = S_RSV_MARK;
            end
            S_RSV_MARK:
            begin
                // written after the swap so a top page reserving itself ends reserved
                b_we        = 1'b1;
                b_waddr     = j_reg;
                b_wdata.st  = pfsa_pkg::PG_RSVD;
                b_wdata.pos = '0;
                fc_next     = fc_dec;
                done_next   = done_reg + CW'(1);
                j_next      = j_reg + PW'(1);
                state_next  = S_PG_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_status_next = status_reg;
                    out_addr_next   = addr_reg;
                    out_done_next   = done_reg;
                    out_free_next   = fc_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // config write transaction
        if (cfg.valid)
        begin
            unique case (cfg.idx)
                pfsa_pkg::REG_BASE_ADDRESS:  base_next  = cfg.data[pfsa_pkg::BASE_W-1:0];
                pfsa_pkg::REG_PAGE_SIZE:     psize_next = cfg.data[pfsa_pkg::PSIZE_W-1:0];
                pfsa_pkg::REG_CONTROL_PAGES: ctrl_next  = cfg.data[pfsa_pkg::CTRL_W-1:0];
                pfsa_pkg::REG_USABLE_PAGES:
                begin
                    pool_next  = pool_wr;
                    fc_next    = pool_wr;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            fc_reg        <= CW'(pfsa_pkg::MAX_PAGES);
            pool_reg      <= CW'(pfsa_pkg::MAX_PAGES);
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            psize_reg     <= pfsa_pkg::PSIZE_W'(4096);
            ctrl_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fc_reg        <= fc_next;
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            psize_reg     <= psize_next;
            ctrl_reg      <= ctrl_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        first_reg      <= first_next;
        count_reg      <= count_next;
        j_reg          <= j_next;
        pos_reg        <= pos_next;
        done_reg       <= done_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_done_reg   <= out_done_next;
        out_free_reg   <= out_free_next;
    end

    // free count never exceeds the pool
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= pool_reg)
        else $error("free count above pool size");

    // an allocation pops exactly one page
    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_MUL) |=> (fc_reg == $past(fc_reg) - CW'(1)))
        else $error("allocation did not pop one page");

    // a range never changes more pages than requested
    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && act_reg != pfsa_pkg::ACT_ALLOC) |-> (done_reg <= count_reg))
        else $error("pages done exceeds page count");

endmodule
